### rtl/shc_pkg.sv
// ----------------------------------------------------------------------------
// shc_pkg
// Shared types and constants for the state co-occurrence histogram.
// ----------------------------------------------------------------------------
package shc_pkg;

	// Default sizes for the top-level parameters
	localparam int DEF_NUM_STATES  = 11;
	localparam int DEF_SIMUL_LIMIT = 5;
	localparam int DEF_COUNT_WIDTH = 32;

	// Fixed by the field widths of a beat
	localparam int STATE_W    = 4;
	localparam int MAX_RECORD = 9;
	localparam logic [7:0] DIGIT_ZERO = 8'h30;

	typedef enum logic [1:0] {
		FUNC_CHAR     = 2'd0,
		FUNC_EOL      = 2'd1,
		FUNC_RD_STATE = 2'd2,
		FUNC_RD_PAIR  = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		STAT_OK    = 3'd0,
		STAT_DONE  = 3'd1,
		STAT_BAD   = 3'd2,
		STAT_RANGE = 3'd3,
		STAT_CUT   = 3'd4
	} status_t;

	typedef struct packed {
		func_t               func;
		logic [7:0]          char_code;
		logic [STATE_W-1:0]  bin_row;
		logic [STATE_W-1:0]  bin_col;
	} req_t;

	typedef struct packed {
		logic [31:0] count_value;
		status_t     status;
	} rsp_t;

	// State bin address source
	typedef enum logic [1:0] {
		SB_EMPTY = 2'd0,
		SB_STATE = 2'd1,
		SB_READ  = 2'd2
	} sb_src_t;

	// Pair bin address source
	typedef enum logic {
		PB_BUMP = 1'b0,
		PB_READ = 1'b1
	} pb_src_t;

	// Result value source
	typedef enum logic [1:0] {
		RES_NONE = 2'd0,
		RES_SB   = 2'd1,
		RES_PB   = 2'd2
	} res_src_t;

	// Controller to datapath commands
	typedef struct packed {
		logic     load;
		logic     set_record;
		logic     abort;
		logic     store_state;
		logic     sb_rd;
		sb_src_t  sb_src;
		logic     sb_wr;
		logic     pb_rd;
		pb_src_t  pb_src;
		logic     pb_wr;
		logic     pair_next;
		logic     note;
		status_t  note_status;
		res_src_t note_src;
		logic     res_load;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		func_t func;
		logic  expect_count;
		logic  is_digit;
		logic  count_zero;
		logic  state_ok;
		logic  size_lt_limit;
		logic  has_prev;
		logic  last_state;
		logic  pass;
		logic  pair_last;
		logic  rd_sb_ok;
		logic  rd_pb_ok;
		logic  out_free;
	} stat_t;

endpackage

### rtl/state_cooccurrence_histogram.sv
// ----------------------------------------------------------------------------
// state_cooccurrence_histogram
// Record parser with saturating state and state-pair histograms.
// ----------------------------------------------------------------------------
// One beat is in work at a time; req_ready is high only while the block waits
// for a beat, and a finished result sits in the output register so the next
// beat can be taken while it waits. An end of line, a bad character, a count
// digit or a bin read goes from decode straight to the result; a zero count
// first bumps a state bin. A state digit bumps its simultaneity bin when that
// is counted, then walks the pair bins of the k earlier states of the record,
// k up to 8, then stores its state. Each pair bin bump is a read and a write
// on the single-port pair memory, and each earlier state bumps two bins. Both
// histograms read as zero right after reset through per-entry valid bits,
// with no clearing pass.
// ----------------------------------------------------------------------------
module state_cooccurrence_histogram
	import shc_pkg::*;
#(
	parameter int NUM_STATES  = DEF_NUM_STATES,
	parameter int SIMUL_LIMIT = DEF_SIMUL_LIMIT,
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	cmd_t  cmd;
	stat_t stat;

	// Sequencer
	shc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Parse registers, bin memories and result register
	shc_dpath #(
		.NUM_STATES  (NUM_STATES),
		.SIMUL_LIMIT (SIMUL_LIMIT),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

### rtl/shc_ctrl.sv
// ----------------------------------------------------------------------------
// shc_ctrl
// Sequencer: decodes each beat and steps the bin read-modify-write walk.
// ----------------------------------------------------------------------------
module shc_ctrl
	import shc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	output logic  req_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECODE = 3'd1;
	localparam logic [2:0] ST_SB_WR  = 3'd2;
	localparam logic [2:0] ST_PB_RD  = 3'd3;
	localparam logic [2:0] ST_PB_WR  = 3'd4;
	localparam logic [2:0] ST_FINISH = 3'd5;
	localparam logic [2:0] ST_RESULT = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Hold the current step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next step and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.note     = 1'b1;
				cmd.note_src = RES_NONE;
				state_d      = ST_RESULT;
				unique case (stat.func)
					FUNC_CHAR: begin
						if (stat.expect_count) begin
							if (!stat.is_digit) begin
								cmd.note_status = STAT_BAD;
							end else if (stat.count_zero) begin
								cmd.note_status = STAT_DONE;
								cmd.sb_rd       = 1'b1;
								cmd.sb_src      = SB_EMPTY;
								state_d         = ST_SB_WR;
							end else begin
								cmd.note_status = STAT_OK;
								cmd.set_record  = 1'b1;
							end
						end else if (!stat.state_ok) begin
							cmd.note_status = STAT_RANGE;
							cmd.abort       = 1'b1;
						end else if (stat.size_lt_limit) begin
							cmd.sb_rd  = 1'b1;
							cmd.sb_src = SB_STATE;
							state_d    = ST_SB_WR;
						end else if (stat.has_prev) begin
							state_d = ST_PB_RD;
						end else begin
							state_d = ST_FINISH;
						end
					end
					FUNC_EOL: begin
						if (!stat.expect_count) begin
							cmd.note_status = STAT_CUT;
							cmd.abort       = 1'b1;
						end else begin
							cmd.note_status = STAT_OK;
						end
					end
					FUNC_RD_STATE: begin
						cmd.note_status = STAT_OK;
						if (stat.rd_sb_ok) begin
							cmd.note_src = RES_SB;
							cmd.sb_rd    = 1'b1;
							cmd.sb_src   = SB_READ;
						end
					end
					FUNC_RD_PAIR: begin
						cmd.note_status = STAT_OK;
						if (stat.rd_pb_ok) begin
							cmd.note_src = RES_PB;
							cmd.pb_rd    = 1'b1;
							cmd.pb_src   = PB_READ;
						end
					end
					default: begin
						cmd.note_status = STAT_OK;
					end
				endcase
			end
			ST_SB_WR: begin
				cmd.sb_wr = 1'b1;
				if (stat.expect_count) begin
					state_d = ST_RESULT;
				end else if (stat.has_prev) begin
					state_d = ST_PB_RD;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_PB_RD: begin
				cmd.pb_rd  = 1'b1;
				cmd.pb_src = PB_BUMP;
				state_d    = ST_PB_WR;
			end
			ST_PB_WR: begin
				cmd.pb_wr     = 1'b1;
				cmd.pair_next = 1'b1;
				if (stat.pass && stat.pair_last) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_PB_RD;
				end
			end
			ST_FINISH: begin
				cmd.store_state = 1'b1;
				cmd.note        = 1'b1;
				cmd.note_src    = RES_NONE;
				cmd.note_status = stat.last_state ? STAT_DONE : STAT_OK;
				state_d         = ST_RESULT;
			end
			ST_RESULT: begin
				if (stat.out_free) begin
					cmd.res_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/shc_dpath.sv
// ----------------------------------------------------------------------------
// shc_dpath
// Parse registers, state and pair bin memories, and the result register.
// ----------------------------------------------------------------------------
module shc_dpath
	import shc_pkg::*;
#(
	parameter int NUM_STATES  = DEF_NUM_STATES,
	parameter int SIMUL_LIMIT = DEF_SIMUL_LIMIT,
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  cmd_t  cmd,
	output stat_t stat,
	input  req_t  req,
	output logic  rsp_valid,
	input  logic  rsp_ready,
	output rsp_t  rsp
);

	localparam int SB_DEPTH = NUM_STATES * SIMUL_LIMIT;
	localparam int PB_DEPTH = NUM_STATES * NUM_STATES;
	localparam int SB_AW    = $clog2(SB_DEPTH);
	localparam int PB_AW    = $clog2(PB_DEPTH);
	localparam int RS_AW    = $clog2(MAX_RECORD);

	// Captured beat
	req_t req_q;

	// Parse state
	logic               expect_count_q;
	logic [STATE_W-1:0] record_size_q;
	logic [STATE_W-1:0] states_seen_q;
	logic [STATE_W-1:0] record_states_q [MAX_RECORD];
	logic [STATE_W-1:0] pair_idx_q;
	logic               pass_q;

	// Bin memories with per-entry valid bits
	logic [COUNT_WIDTH-1:0] sb_mem [SB_DEPTH];
	logic [COUNT_WIDTH-1:0] pb_mem [PB_DEPTH];
	logic [SB_DEPTH-1:0]    sb_valid_q;
	logic [PB_DEPTH-1:0]    pb_valid_q;
	logic [COUNT_WIDTH-1:0] sb_rdata_q;
	logic [COUNT_WIDTH-1:0] pb_rdata_q;
	logic                   sb_rvalid_q;
	logic                   pb_rvalid_q;
	logic [SB_AW-1:0]       sb_addr_q;
	logic [PB_AW-1:0]       pb_addr_q;

	// Result
	status_t     res_status_q;
	res_src_t    res_src_q;
	logic        out_valid_q;
	logic [31:0] res_value_q;
	status_t     res_out_q;

	logic [7:0]             char_off;
	logic [STATE_W-1:0]     state_w;
	logic [STATE_W-1:0]     partner;
	logic [SB_AW-1:0]       sb_addr;
	logic [PB_AW-1:0]       pb_addr;
	logic [COUNT_WIDTH-1:0] sb_cnt;
	logic [COUNT_WIDTH-1:0] pb_cnt;
	logic [COUNT_WIDTH-1:0] sb_inc;
	logic [COUNT_WIDTH-1:0] pb_inc;
	logic [63:0]            sb_wide;
	logic [63:0]            pb_wide;
	logic [31:0]            res_value;

	// Decode the captured character
	assign char_off = req_q.char_code - DIGIT_ZERO;
	assign state_w  = char_off[STATE_W-1:0] + STATE_W'(1);
	assign partner  = record_states_q[pair_idx_q[RS_AW-1:0]];

	assign stat.func          = req_q.func;
	assign stat.expect_count  = expect_count_q;
	assign stat.is_digit      = (req_q.char_code >= DIGIT_ZERO) &&
	                            (req_q.char_code <= DIGIT_ZERO + 8'd9);
	assign stat.count_zero    = (req_q.char_code == DIGIT_ZERO);
	assign stat.state_ok      = (req_q.char_code >= DIGIT_ZERO) &&
	                            (char_off < 8'(NUM_STATES - 1));
	assign stat.size_lt_limit = (record_size_q < STATE_W'(SIMUL_LIMIT));
	assign stat.has_prev      = (states_seen_q != '0);
	assign stat.last_state    = ((states_seen_q + STATE_W'(1)) >= record_size_q);
	assign stat.pass          = pass_q;
	assign stat.pair_last     = ((pair_idx_q + STATE_W'(1)) == states_seen_q);
	assign stat.rd_sb_ok      = (req_q.bin_row < STATE_W'(NUM_STATES)) &&
	                            (req_q.bin_col < STATE_W'(SIMUL_LIMIT));
	assign stat.rd_pb_ok      = (req_q.bin_row < STATE_W'(NUM_STATES)) &&
	                            (req_q.bin_col < STATE_W'(NUM_STATES));
	assign stat.out_free      = !out_valid_q || rsp_ready;

	// Select bin addresses
	always_comb begin
		unique case (cmd.sb_src)
			SB_EMPTY: sb_addr = '0;
			SB_STATE: sb_addr = SB_AW'(state_w * SIMUL_LIMIT + record_size_q);
			SB_READ:  sb_addr = SB_AW'(req_q.bin_row * SIMUL_LIMIT + req_q.bin_col);
			default:  sb_addr = '0;
		endcase
	end

	always_comb begin
		unique case (cmd.pb_src)
			PB_BUMP: pb_addr = pass_q ? PB_AW'(partner * NUM_STATES + state_w)
			                          : PB_AW'(state_w * NUM_STATES + partner);
			PB_READ: pb_addr = PB_AW'(req_q.bin_row * NUM_STATES + req_q.bin_col);
			default: pb_addr = '0;
		endcase
	end

	// Saturating increment of the fetched counts; unwritten entries read as zero
	assign sb_cnt = sb_rvalid_q ? sb_rdata_q : '0;
	assign pb_cnt = pb_rvalid_q ? pb_rdata_q : '0;
	assign sb_inc = (sb_cnt == '1) ? sb_cnt : sb_cnt + COUNT_WIDTH'(1);
	assign pb_inc = (pb_cnt == '1) ? pb_cnt : pb_cnt + COUNT_WIDTH'(1);

	// Clamp to the 32-bit result field
	assign sb_wide = 64'(sb_cnt);
	assign pb_wide = 64'(pb_cnt);

	always_comb begin
		unique case (res_src_q)
			RES_NONE: res_value = '0;
			RES_SB:   res_value = (sb_wide > 64'hFFFF_FFFF) ? '1 : sb_wide[31:0];
			RES_PB:   res_value = (pb_wide > 64'hFFFF_FFFF) ? '1 : pb_wide[31:0];
			default:  res_value = '0;
		endcase
	end

	// Capture the beat
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
	end

	// Record the state of this position
	always_ff @(posedge clk) begin
		if (cmd.store_state) begin
			record_states_q[states_seen_q[RS_AW-1:0]] <= state_w;
		end
	end

	// Advance the parse and pair walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_count_q <= 1'b1;
			record_size_q  <= '0;
			states_seen_q  <= '0;
			pair_idx_q     <= '0;
			pass_q         <= 1'b0;
		end else begin
			if (cmd.load) begin
				pair_idx_q <= '0;
				pass_q     <= 1'b0;
			end else if (cmd.pair_next) begin
				pass_q <= !pass_q;
				if (pass_q) begin
					pair_idx_q <= pair_idx_q + STATE_W'(1);
				end
			end
			if (cmd.set_record) begin
				record_size_q  <= char_off[STATE_W-1:0];
				states_seen_q  <= '0;
				expect_count_q <= 1'b0;
			end
			if (cmd.abort) begin
				expect_count_q <= 1'b1;
			end
			if (cmd.store_state) begin
				states_seen_q <= states_seen_q + STATE_W'(1);
				if (stat.last_state) begin
					expect_count_q <= 1'b1;
				end
			end
		end
	end

	// Bin memories: registered read, write back in the following cycle
	always_ff @(posedge clk) begin
		if (cmd.sb_rd) begin
			sb_rdata_q  <= sb_mem[sb_addr];
			sb_rvalid_q <= sb_valid_q[sb_addr];
			sb_addr_q   <= sb_addr;
		end
		if (cmd.sb_wr) begin
			sb_mem[sb_addr_q] <= sb_inc;
		end
		if (cmd.pb_rd) begin
			pb_rdata_q  <= pb_mem[pb_addr];
			pb_rvalid_q <= pb_valid_q[pb_addr];
			pb_addr_q   <= pb_addr;
		end
		if (cmd.pb_wr) begin
			pb_mem[pb_addr_q] <= pb_inc;
		end
	end

	// Mark written entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sb_valid_q <= '0;
			pb_valid_q <= '0;
		end else begin
			if (cmd.sb_wr) begin
				sb_valid_q[sb_addr_q] <= 1'b1;
			end
			if (cmd.pb_wr) begin
				pb_valid_q[pb_addr_q] <= 1'b1;
			end
		end
	end

	// Hold the pending result code and source
	always_ff @(posedge clk) begin
		if (cmd.note) begin
			res_status_q <= cmd.note_status;
			res_src_q    <= cmd.note_src;
		end
		if (cmd.res_load) begin
			res_value_q <= res_value;
			res_out_q   <= res_status_q;
		end
	end

	// Output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp_valid       = out_valid_q;
	assign rsp.count_value = res_value_q;
	assign rsp.status      = res_out_q;

	// A new result never overwrites one still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> (!out_valid_q || rsp_ready))
		else $error("result overwrites a pending beat");

	// Inside a record fewer states have been seen than announced
	assert property (@(posedge clk) disable iff (!arst_n)
		!expect_count_q |-> (states_seen_q < record_size_q))
		else $error("record state count overran its size");

	// The pair walk stays among earlier positions of the record
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pb_wr && !cmd.pb_rd |-> (pair_idx_q < states_seen_q))
		else $error("pair walk past the stored states");

	// A written pair bin reads as valid afterwards
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pb_wr |=> pb_valid_q[$past(pb_addr_q)])
		else $error("pair bin valid bit not set after write");

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the state co-occurrence histogram.
// ----------------------------------------------------------------------------
// A short table of hand-picked beats comes first: reads right after reset,
// out-of-range reads, bad count bytes, a zero count, a state past the table,
// a record cut by end of line and a simultaneity count at the limit. After
// it come random records, mostly well formed with random state digits, with
// reads, cut records, bad states and raw noise mixed in. A cycle-free model
// of the parser and both histograms predicts every result at the input
// handshake, unless a table row gives it. Each result beat is checked field
// by field against the oldest prediction. Both sides idle at random. Once the
// result side holds off for a long stretch while beats keep coming, and twice
// the request side drains every result before it goes on.
// ----------------------------------------------------------------------------
module tb_top
	import shc_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NS          = DEF_NUM_STATES;
	localparam int SL          = DEF_SIMUL_LIMIT;
	localparam int N_DIRECTED  = 25;
	localparam int N_RANDOM    = 650;
	localparam int QUIET_LIMIT = 3000;
	localparam int LONG_HOLD   = 400;
	localparam int DRAIN_CYCLES = 64;

	// One row of the hand-picked table; typed_in marks a result given here
	typedef struct packed {
		func_t       func;
		logic [7:0]  ch;
		logic [3:0]  row;
		logic [3:0]  col;
		logic        typed_in;
		logic [31:0] value;
		status_t     status;
	} dir_row_t;

	typedef struct {
		req_t beat;
		bit   typed_in;
		rsp_t want;
	} plan_row_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	state_cooccurrence_histogram dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Model of the parser and the two histograms
	logic        awaiting_count = 1'b1;
	logic [3:0]  rec_len        = '0;
	logic [3:0]  rec_fill       = '0;
	logic [3:0]  rec_states [MAX_RECORD];
	logic [31:0] state_hist [NS*SL] = '{default: '0};
	logic [31:0] pair_hist  [NS*NS] = '{default: '0};

	plan_row_t   beat_plan [$];
	rsp_t        expected_rsps [$];
	dir_row_t    directed_tbl [N_DIRECTED];
	int          beats_in   = 0;
	int          beats_out  = 0;
	int          mismatches = 0;
	int          quiet_cycles = 0;

	function automatic void bump_bin(inout logic [31:0] bin);
		if (bin != '1)
			bin = bin + 32'd1;
	endfunction

	function automatic status_t parse_char(logic [7:0] c);
		int s;
		int p;
		int k;
		if (awaiting_count) begin
			if (c < DIGIT_ZERO || c > DIGIT_ZERO + 8'd9)
				return STAT_BAD;
			if (c == DIGIT_ZERO) begin
				bump_bin(state_hist[0]);
				return STAT_DONE;
			end
			rec_len = 4'(c - DIGIT_ZERO);
			rec_fill = '0;
			awaiting_count = 1'b0;
			return STAT_OK;
		end
		// only '0'..'9' map into the state table
		if (c < DIGIT_ZERO || int'(c - DIGIT_ZERO) + 1 >= NS) begin
			awaiting_count = 1'b1;
			return STAT_RANGE;
		end
		s = int'(c - DIGIT_ZERO) + 1;
		if (rec_len < SL)
			bump_bin(state_hist[s*SL + rec_len]);
		// pair every earlier state of the record with this one, both orders
		for (k = 0; k < rec_fill; k++) begin
			p = int'(rec_states[k]);
			bump_bin(pair_hist[s*NS + p]);
			bump_bin(pair_hist[p*NS + s]);
		end
		if (rec_fill < MAX_RECORD)
			rec_states[rec_fill] = 4'(s);
		rec_fill = rec_fill + 4'd1;
		if (rec_fill >= rec_len) begin
			awaiting_count = 1'b1;
			return STAT_DONE;
		end
		return STAT_OK;
	endfunction

	function automatic rsp_t histogram_step(req_t b);
		rsp_t r;
		r.count_value = '0;
		r.status = STAT_OK;
		case (b.func)
			FUNC_CHAR: r.status = parse_char(b.char_code);
			FUNC_EOL: begin
				if (!awaiting_count) begin
					awaiting_count = 1'b1;
					r.status = STAT_CUT;
				end
			end
			FUNC_RD_STATE: begin
				if (b.bin_row < NS && b.bin_col < SL)
					r.count_value = state_hist[b.bin_row*SL + b.bin_col];
			end
			default: begin
				if (b.bin_row < NS && b.bin_col < NS)
					r.count_value = pair_hist[b.bin_row*NS + b.bin_col];
			end
		endcase
		return r;
	endfunction

	task automatic flag_mismatch(string what);
		mismatches++;
		$display("mismatch at result %0d: %s", beats_out, what);
	endtask

	function automatic void queue_beat(func_t f, logic [7:0] ch, logic [3:0] r, logic [3:0] c);
		plan_row_t pr;
		pr.beat.func = f;
		pr.beat.char_code = ch;
		pr.beat.bin_row = r;
		pr.beat.bin_col = c;
		pr.typed_in = 1'b0;
		pr.want = '0;
		beat_plan.push_back(pr);
	endfunction

	function automatic void queue_read();
		func_t f;
		logic [3:0] r;
		logic [3:0] c;
		f = $urandom_range(0, 1) ? FUNC_RD_STATE : FUNC_RD_PAIR;
		r = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 10));
		if ($urandom_range(0, 7) == 0)
			c = 4'($urandom_range(0, 15));
		else if (f == FUNC_RD_STATE)
			c = 4'($urandom_range(0, SL - 1));
		else
			c = 4'($urandom_range(0, NS - 1));
		queue_beat(f, 8'($urandom_range(0, 255)), r, c);
	endfunction

	function automatic logic [7:0] non_digit_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if (b >= DIGIT_ZERO && b <= DIGIT_ZERO + 8'd9)
			b = b ^ 8'h80;
		return b;
	endfunction

	// Mostly whole records with random digits, some broken, plus reads and noise
	function automatic void plan_random(int target);
		int kind;
		int n;
		int k;
		int cut_at;
		while (beat_plan.size() < N_DIRECTED + target) begin
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				n = ($urandom_range(0, 4) == 0) ? 9 : $urandom_range(0, 9);
				cut_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n) : -1;
				queue_beat(FUNC_CHAR, 8'(DIGIT_ZERO + n), 4'($urandom_range(0, 15)),
					4'($urandom_range(0, 15)));
				for (k = 0; k < n; k++) begin
					if (k == cut_at) begin
						if ($urandom_range(0, 1))
							queue_beat(FUNC_EOL, 8'($urandom_range(0, 255)),
								4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
						else
							queue_beat(FUNC_CHAR, non_digit_byte(),
								4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
						break;
					end
					if ($urandom_range(0, 9) == 0)
						queue_read();
					queue_beat(FUNC_CHAR, 8'(DIGIT_ZERO + $urandom_range(0, 9)),
						4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
				end
				if ($urandom_range(0, 3) == 0)
					queue_beat(FUNC_EOL, 8'($urandom_range(0, 255)),
						4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
			end else if (kind < 88) begin
				queue_read();
			end else begin
				queue_beat(func_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
					4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
			end
		end
	endfunction

	// Idle cycles before the next beat, with runs of back-to-back beats
	function automatic int draw_gap(inout int run_left);
		if (run_left > 0) begin
			run_left--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0)
			run_left = $urandom_range(10, 30);
		return $urandom_range(0, 15);
	endfunction

	// Predict on request beats, check result beats
	always @(posedge clk) begin
		rsp_t want;
		if (req_valid && req_ready) begin
			want = histogram_step(req);
			if (beat_plan[beats_in].typed_in)
				want = beat_plan[beats_in].want;
			expected_rsps.push_back(want);
			beats_in++;
		end
		if (rsp_valid && rsp_ready) begin
			if (expected_rsps.size() == 0) begin
				flag_mismatch("result beat with nothing expected");
			end else begin
				want = expected_rsps.pop_front();
				if (rsp.count_value !== want.count_value)
					flag_mismatch($sformatf("count_value %0h, expected %0h",
						rsp.count_value, want.count_value));
				if (rsp.status !== want.status)
					flag_mismatch($sformatf("status %0d, expected %0d",
						rsp.status, want.status));
			end
			beats_out++;
		end
	end

	// Stop the run when no beat moves for too long
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Result side: random ready, one long hold-off
	initial begin : sink
		int gap;
		int run_left;
		bit held_off;
		run_left = 0;
		held_off = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			gap = draw_gap(run_left);
			if (!held_off && beats_in >= N_DIRECTED + 150) begin
				held_off = 1'b1;
				gap = LONG_HOLD;
			end
			if (gap > 0) begin
				rsp_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	// Request side: reset, table, random beats, drain and verdict
	initial begin : source
		int idx;
		int gap;
		int run_left;
		bit pause;
		plan_row_t pr;
		run_left = 0;

		directed_tbl = '{
			'{FUNC_RD_STATE, 8'h00, 4'd0,  4'd0,  1'b1, 32'd0, STAT_OK},
			'{FUNC_RD_PAIR,  8'hFF, 4'd10, 4'd10, 1'b1, 32'd0, STAT_OK},
			'{FUNC_RD_STATE, 8'h00, 4'd15, 4'd15, 1'b1, 32'd0, STAT_OK},
			'{FUNC_RD_STATE, 8'h00, 4'd10, 4'd5,  1'b1, 32'd0, STAT_OK},
			'{FUNC_RD_PAIR,  8'h00, 4'd11, 4'd0,  1'b1, 32'd0, STAT_OK},
			'{FUNC_EOL,      8'hFF, 4'd15, 4'd15, 1'b1, 32'd0, STAT_OK},
			'{FUNC_CHAR,     8'h00, 4'd0,  4'd0,  1'b1, 32'd0, STAT_BAD},
			'{FUNC_CHAR,     8'hFF, 4'd15, 4'd15, 1'b1, 32'd0, STAT_BAD},
			'{FUNC_CHAR,     8'h3A, 4'd0,  4'd0,  1'b1, 32'd0, STAT_BAD},
			'{FUNC_CHAR,     8'h2F, 4'd0,  4'd0,  1'b1, 32'd0, STAT_BAD},
			'{FUNC_CHAR,     8'h30, 4'd0,  4'd0,  1'b1, 32'd0, STAT_DONE},
			'{FUNC_RD_STATE, 8'h00, 4'd0,  4'd0,  1'b1, 32'd1, STAT_OK},
			'{FUNC_CHAR,     8'h32, 4'd0,  4'd0,  1'b0, 32'd0, STAT_OK},
			'{FUNC_CHAR,     8'h30, 4'd0,  4'd0,  1'b0, 32'd0, STAT_OK},
			'{FUNC_CHAR,     8'h39, 4'd0,  4'd0,  1'b0, 32'd0, STAT_OK},
			'{FUNC_RD_PAIR,  8'h00, 4'd1,  4'd10, 1'b0, 32'd0, STAT_OK},
			'{FUNC_RD_STATE, 8'h00, 4'd10, 4'd2,  1'b0, 32'd0, STAT_OK},
			'{FUNC_CHAR,     8'h33, 4'd0,  4'd0,  1'b0, 32'd0, STAT_OK},
			'{FUNC_CHAR,     8'h34, 4'd0,  4'd0,  1'b0, 32'd0, STAT_OK},
			'{FUNC_CHAR,     8'hFF, 4'd0,  4'd0,  1'b1, 32'd0, STAT_RANGE},
			'{FUNC_CHAR,     8'h35, 4'd0,  4'd0,  1'b0, 32'd0, STAT_OK},
			'{FUNC_CHAR,     8'h37, 4'd0,  4'd0,  1'b0, 32'd0, STAT_OK},
			'{FUNC_EOL,      8'h00, 4'd0,  4'd0,  1'b1, 32'd0, STAT_CUT},
			'{FUNC_CHAR,     8'h31, 4'd0,  4'd0,  1'b0, 32'd0, STAT_OK},
			'{FUNC_CHAR,     8'h2F, 4'd0,  4'd0,  1'b1, 32'd0, STAT_RANGE}
		};
		for (idx = 0; idx < N_DIRECTED; idx++) begin
			pr.beat.func = directed_tbl[idx].func;
			pr.beat.char_code = directed_tbl[idx].ch;
			pr.beat.bin_row = directed_tbl[idx].row;
			pr.beat.bin_col = directed_tbl[idx].col;
			pr.typed_in = directed_tbl[idx].typed_in;
			pr.want.count_value = directed_tbl[idx].value;
			pr.want.status = directed_tbl[idx].status;
			beat_plan.push_back(pr);
		end
		plan_random(N_RANDOM);

		// hold reset, then release on an edge
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (idx = 0; idx < beat_plan.size(); idx++) begin
			gap = draw_gap(run_left);
			// drain every result after the table and once mid-run
			pause = (idx == N_DIRECTED) || (idx == N_DIRECTED + 400);
			if (pause && gap == 0)
				gap = 1;
			if (gap > 0) begin
				req_valid <= 1'b0;
				if (pause) begin
					@(posedge clk);
					gap--;
					while (expected_rsps.size() != 0) @(posedge clk);
				end
				repeat (gap) @(posedge clk);
			end
			req <= beat_plan[idx].beat;
			req_valid <= 1'b1;
			do @(posedge clk); while (!req_ready);
		end
		req_valid <= 1'b0;
		@(posedge clk);

		// wait for the last results, then let the block settle
		while (expected_rsps.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
